FILE: src/rrtr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task ring package
// Request and response types, function codes and status codes shared by the
// task ring and its checker.
// ----------------------------------------------------------------------------
package rrtr_pkg;

	localparam logic [2:0] FN_INSERT   = 3'd0;
	localparam logic [2:0] FN_YIELD    = 3'd1;
	localparam logic [2:0] FN_GETID    = 3'd2;
	localparam logic [2:0] FN_GETTICKS = 3'd3;
	localparam logic [2:0] FN_TICK     = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_NOT_IN_USE = 2'd2;
	localparam logic [1:0] ST_UNUSED     = 2'd3;

	typedef struct packed {
		logic [2:0] func;
		logic [9:0] after_slot;
	} req_t;

	typedef struct packed {
		logic [9:0]  current_slot;
		logic [31:0] current_task_id;
		logic [31:0] return_value;
		logic [1:0]  status;
	} rsp_t;

endpackage
`default_nettype wire

FILE: src/rrtr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/rrtr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task ring sequencer
// Issues the ring table read for each request, applies the request to the
// scheduler registers, writes links back and holds the response register.
// ----------------------------------------------------------------------------
module rrtr_core #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire rrtr_pkg::req_t               req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output rrtr_pkg::rsp_t                    rsp,
	output logic                              mem_rd_en,
	output logic [$clog2(MAX_SLOTS)-1:0]      mem_rd_addr,
	input  wire logic [$clog2(MAX_SLOTS)+31:0] mem_rd_data,
	output logic                              mem_wr_en,
	output logic [$clog2(MAX_SLOTS)-1:0]      mem_wr_addr,
	output logic [$clog2(MAX_SLOTS)+31:0]     mem_wr_data
);

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int EW = SW + 32;
	localparam int CW = (SW > 10) ? SW : 10;
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LINK = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [2:0]    func_s1;
	logic [CW-1:0] after_s1;
	logic          rd_zero_s1;

	logic [SW-1:0] run_q, run_d;
	logic [31:0]   tid_q, tid_d;
	logic [SW-1:0] used_q, used_d;
	logic [31:0]   last_q, last_d;
	logic [31:0]   tick_q, tick_d;
	logic          link0_vld_q;

	logic           rsp_valid_q;
	rrtr_pkg::rsp_t rsp_q;

	logic           req_fire;
	logic           out_free;
	logic           commit;
	logic [CW-1:0]  after_ext;
	logic [CW-1:0]  used_ext;
	logic [CW-1:0]  run_ext;
	logic [EW-1:0]  ent;
	logic [SW-1:0]  ent_next;
	logic [31:0]    ent_tid;
	logic [SW-1:0]  fresh;
	logic [31:0]    ret_d;
	logic [1:0]     status_d;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign commit    = (state_q == S_EXEC) && out_free;

	assign after_ext   = CW'(req.after_slot);
	assign mem_rd_en   = req_fire;
	assign mem_rd_addr = (req.func == rrtr_pkg::FN_INSERT) ? after_ext[SW-1:0] : run_q;

	assign ent      = (rd_zero_s1 && !link0_vld_q) ? '0 : mem_rd_data;
	assign ent_next = ent[SW-1:0];
	assign ent_tid  = ent[EW-1:SW];
	assign used_ext = CW'(used_q);
	assign fresh    = used_q + SW'(1);

	always_comb begin
		state_d     = state_q;
		run_d       = run_q;
		tid_d       = tid_q;
		used_d      = used_q;
		last_d      = last_q;
		tick_d      = tick_q;
		ret_d       = '0;
		status_d    = rrtr_pkg::ST_OK;
		mem_wr_en   = 1'b0;
		mem_wr_addr = fresh;
		mem_wr_data = ent;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
					case (func_s1)
						rrtr_pkg::FN_INSERT: begin
							if (after_s1 > used_ext) begin
								status_d = rrtr_pkg::ST_NOT_IN_USE;
							end else begin
								last_d = last_q + 32'd1;
								if (used_q == LAST_SLOT) begin
									status_d = rrtr_pkg::ST_FULL;
								end else begin
									used_d    = fresh;
									mem_wr_en = 1'b1;
									state_d   = S_LINK;
								end
							end
						end
						rrtr_pkg::FN_YIELD: begin
							run_d = ent_next;
							tid_d = ent_tid;
						end
						rrtr_pkg::FN_GETID: begin
							ret_d = tid_q;
						end
						rrtr_pkg::FN_GETTICKS: begin
							ret_d = tick_q;
						end
						rrtr_pkg::FN_TICK: begin
							tick_d = tick_q + 32'd1;
							run_d  = ent_next;
							tid_d  = ent_tid;
						end
						default: begin
						end
					endcase
				end
			end
			S_LINK: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = after_s1[SW-1:0];
				mem_wr_data = {last_q, used_q};
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign run_ext = CW'(run_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_q       <= '0;
			tid_q       <= '0;
			used_q      <= '0;
			last_q      <= '0;
			tick_q      <= '0;
			link0_vld_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
			tid_q   <= tid_d;
			used_q  <= used_d;
			last_q  <= last_d;
			tick_q  <= tick_d;
			if (mem_wr_en && (mem_wr_addr == '0)) begin
				link0_vld_q <= 1'b1;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_s1    <= req.func;
			after_s1   <= after_ext;
			rd_zero_s1 <= (mem_rd_addr == '0);
		end
		if (commit) begin
			rsp_q.current_slot    <= run_ext[9:0];
			rsp_q.current_task_id <= tid_d;
			rsp_q.return_value    <= ret_d;
			rsp_q.status          <= status_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

FILE: src/round_robin_task_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task ring
// Circular list of scheduler tasks kept in a ring table memory.
// ----------------------------------------------------------------------------
// Each ring table entry holds the next slot of the ring together with the
// task id stored in that next slot, so a yield or a tick reaches both with
// one read. The accept cycle of a request reads the ring table; the
// execute state then updates the scheduler registers and loads the
// response register when it is free. An insert adds a link state: its two
// link writes share the ring table's single write port. A request is taken
// while an earlier response still waits, and the block stalls only if that
// response is still not taken when the next one is ready. No clearing pass
// runs after reset; a request may be sent in the first cycle after reset.
// ----------------------------------------------------------------------------
module round_robin_task_ring #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire rrtr_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output rrtr_pkg::rsp_t      rsp
);

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int EW = SW + 32;

	logic          mem_rd_en;
	logic [SW-1:0] mem_rd_addr;
	logic [EW-1:0] mem_rd_data;
	logic          mem_wr_en;
	logic [SW-1:0] mem_wr_addr;
	logic [EW-1:0] mem_wr_data;

	rrtr_core #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data)
	);

	rrtr_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SLOTS)
	) u_ring_ram (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

endmodule
`default_nettype wire

FILE: src/rrtr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task ring checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rrtr_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire rrtr_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire rrtr_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Response changed while stalled.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != rrtr_pkg::ST_UNUSED)
		else $error("Response carries an undefined status code.");

	a_error_ret: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != rrtr_pkg::ST_OK |-> rsp.return_value == 32'd0)
		else $error("Failed insert returned a nonzero value.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request accepted while another is in progress.");

endmodule

bind round_robin_task_ring rrtr_checker u_rrtr_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task ring testbench
// Drives insert, yield, get-id, get-ticks, tick and unused function requests
// with random idle gaps on both channels. A scoreboard keeps its own copy of
// the ring and checks every response in order. The ring is filled until the
// table is full, and the response side stalls long enough to back up the
// request side.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RING_SLOTS = 1024;
	localparam int RANDOM_REQUESTS = 1880;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [2:0] FN_SPARE5 = 3'd5;
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	localparam rrtr_pkg::req_t DIRECTED [22] = '{
		{rrtr_pkg::FN_GETTICKS, 10'd0},
		{rrtr_pkg::FN_GETID, 10'd0},
		{rrtr_pkg::FN_YIELD, 10'd0},
		{rrtr_pkg::FN_TICK, 10'd0},
		{rrtr_pkg::FN_GETTICKS, 10'd0},
		{rrtr_pkg::FN_INSERT, 10'd1},
		{rrtr_pkg::FN_INSERT, 10'd1023},
		{rrtr_pkg::FN_INSERT, 10'd0},
		{rrtr_pkg::FN_YIELD, 10'd0},
		{rrtr_pkg::FN_GETID, 10'd0},
		{rrtr_pkg::FN_INSERT, 10'd1},
		{rrtr_pkg::FN_INSERT, 10'd0},
		{rrtr_pkg::FN_TICK, 10'd1023},
		{rrtr_pkg::FN_YIELD, 10'd0},
		{rrtr_pkg::FN_YIELD, 10'd0},
		{FN_SPARE5, 10'd0},
		{FN_SPARE6, 10'd512},
		{FN_SPARE7, 10'd1023},
		{rrtr_pkg::FN_INSERT, 10'd3},
		{rrtr_pkg::FN_GETTICKS, 10'd0},
		{rrtr_pkg::FN_INSERT, 10'd5},
		{rrtr_pkg::FN_GETID, 10'd0}
	};

	class ring_scoreboard;
		bit [9:0]       next_slot [RING_SLOTS];
		bit [31:0]      slot_tid [RING_SLOTS];
		bit [9:0]       running;
		int             used;
		bit [31:0]      issued_tid;
		bit [31:0]      ticks;
		rrtr_pkg::rsp_t awaited [$];
		int             requests;
		int             responses;
		int             mismatches;
		int             inserted;
		int             full_drops;
		int             unused_targets;

		function new();
			next_slot[0] = '0;
			slot_tid[0] = '0;
			running = '0;
			used = 0;
			issued_tid = '0;
			ticks = '0;
		endfunction

		function rrtr_pkg::rsp_t schedule_step(rrtr_pkg::req_t r);
			rrtr_pkg::rsp_t o;
			bit [9:0] fresh;
			o = '0;
			o.status = rrtr_pkg::ST_OK;
			case (r.func)
				rrtr_pkg::FN_INSERT: begin
					if (int'(r.after_slot) > used) begin
						o.status = rrtr_pkg::ST_NOT_IN_USE;
						unused_targets++;
					end else begin
						issued_tid = issued_tid + 32'd1;
						if (used + 1 >= RING_SLOTS) begin
							o.status = rrtr_pkg::ST_FULL;
							full_drops++;
						end else begin
							used++;
							fresh = 10'(used);
							slot_tid[fresh] = issued_tid;
							next_slot[fresh] = next_slot[r.after_slot];
							next_slot[r.after_slot] = fresh;
							inserted++;
						end
					end
				end
				rrtr_pkg::FN_YIELD: running = next_slot[running];
				rrtr_pkg::FN_GETID: o.return_value = slot_tid[running];
				rrtr_pkg::FN_GETTICKS: o.return_value = ticks;
				rrtr_pkg::FN_TICK: begin
					ticks = ticks + 32'd1;
					running = next_slot[running];
				end
				default: ;
			endcase
			o.current_slot = running;
			o.current_task_id = slot_tid[running];
			return o;
		endfunction

		function void note_request(rrtr_pkg::req_t r);
			requests++;
			awaited.push_back(schedule_step(r));
		endfunction

		function void check_response(rrtr_pkg::rsp_t got);
			rrtr_pkg::rsp_t want;
			responses++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("response %0d arrived with nothing expected:", responses);
					$display("  slot %0d tid %0d ret %0d status %0d",
						got.current_slot, got.current_task_id, got.return_value,
						got.status);
				end
				return;
			end
			want = awaited.pop_front();
			if (got.current_slot !== want.current_slot ||
					got.current_task_id !== want.current_task_id ||
					got.return_value !== want.return_value || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("response %0d: expected slot %0d tid %0d ret %0d status %0d",
						responses, want.current_slot, want.current_task_id,
						want.return_value, want.status);
					$display("  got slot %0d tid %0d ret %0d status %0d",
						got.current_slot, got.current_task_id, got.return_value,
						got.status);
				end
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	rrtr_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	rrtr_pkg::rsp_t rsp;

	ring_scoreboard ring = new();

	round_robin_task_ring #(
		.MAX_SLOTS(RING_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			ring.check_response(rsp);
		if (req_valid && req_ready)
			ring.note_request(req);
	end

	task automatic offer(input rrtr_pkg::req_t r, input int gap, input bit settle);
		if (gap > 0 || settle) begin
			req_valid <= 1'b0;
			repeat (gap + settle) @(posedge clk);
			while (settle && ring.awaited.size() != 0)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	function automatic rrtr_pkg::req_t pick_request(int used);
		rrtr_pkg::req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		r.after_slot = 10'($urandom_range(0, RING_SLOTS - 1));
		if (roll < ((used < RING_SLOTS - 1) ? 80 : 25)) begin
			r.func = rrtr_pkg::FN_INSERT;
			if ($urandom_range(0, 9) != 0)
				r.after_slot = 10'($urandom_range(0, used));
		end else if (roll < 97) begin
			r.func = 3'($urandom_range(int'(rrtr_pkg::FN_YIELD),
				int'(rrtr_pkg::FN_TICK)));
		end else begin
			r.func = 3'($urandom_range(int'(FN_SPARE5), int'(FN_SPARE7)));
		end
		return r;
	endfunction

	initial begin : stimulus
		int k;
		int gap;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (k = 0; k < 22; k++)
			offer(DIRECTED[k], $urandom_range(0, 6), 1'b0);
		for (k = 0; k < RANDOM_REQUESTS; k++) begin
			gap = ((k / 100) % 4 == 3) ? 0 : $urandom_range(0, 6);
			offer(pick_request(ring.used), gap, (k % 1000) == 500);
		end
		req_valid <= 1'b0;
		while (ring.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb_top: %0d requests, %0d responses checked, %0d mismatches",
			ring.requests, ring.responses, ring.mismatches);
		$display("tb_top: %0d tasks linked, %0d dropped full, %0d bad targets, %0d ticks",
			ring.inserted, ring.full_drops, ring.unused_targets, ring.ticks);
		if (ring.mismatches == 0 && ring.awaited.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin : response_side
		int gap;
		int hold_at;
		hold_at = 300;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (ring.responses >= hold_at) begin
				hold_at += 1000;
				rsp_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			gap = ((ring.responses / 90) % 4 == 1) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
